FILE: design/athp_pkg.sv
// athp_pkg: types, constants and field widths shared by the tlv header parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package athp_pkg;

   // default width of the length accumulator
   localparam int LENGTH_BITS_DEFAULT = 32;

   // field widths fixed by the request and result formats
   localparam int BYTE_W   = 8;
   localparam int AVAIL_W  = 32;
   localparam int LEN_W    = 32;
   localparam int OFFSET_W = 5;
   localparam int COUNT_W  = 4;

   // header constants
   localparam logic [BYTE_W-1:0]  BIT_STRING_TAG = 8'h03;
   localparam logic [AVAIL_W:0]   SHORT_HEADER   = 33'd2;
   localparam logic [OFFSET_W-1:0] SHORT_OFFSET  = 5'd2;

   // parse phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_EXT  = 3'd2,
      PH_PAD  = 3'd3
   } phase_type;

   // one accepted request
   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               start_of_element;
      logic [AVAIL_W-1:0] bytes_available;
   } item_type;

   // one result
   typedef struct packed {
      logic                status;
      logic [BYTE_W-1:0]   tag_value;
      logic [LEN_W-1:0]    content_length;
      logic [OFFSET_W-1:0] content_offset;
   } result_type;

endpackage

FILE: design/athp_in_stage.sv
// athp_in_stage: input register of the tlv header parser
// depends on athp_pkg for the request type
`timescale 1ns / 1ps

module athp_in_stage
   import athp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   // stage is free when empty or when its request moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: design/athp_parser.sv
// athp_parser: header parse state, step logic and result register
// depends on athp_pkg for phase, request and result types
`timescale 1ns / 1ps

module athp_parser
   import athp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       advance,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   // parse state
   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      held_tag_ff, held_tag_in;
   logic [AVAIL_W-1:0]     held_avail_ff, held_avail_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0]     ext_left_ff, ext_left_in;
   logic [COUNT_W-1:0]     ext_total_ff, ext_total_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;

   // step terms
   logic [BYTE_W-1:0]      b;
   logic [COUNT_W-1:0]     n;
   logic                   ext_ok;
   logic                   is_bit_string;
   logic [LENGTH_BITS-1:0] acc_shift;
   logic [LENGTH_BITS-1:0] acc_minus1;
   logic                   emit;
   result_type             result;

   // a request moves on when the result register can take an answer
   assign advance = item_valid && (!out_valid_ff || out_ready);

   // shared step terms
   always_comb begin
      b             = item.data_byte;
      n             = b[COUNT_W-1:0];
      ext_ok        = {1'b0, held_avail_ff} >= (SHORT_HEADER + (AVAIL_W+1)'(n));
      is_bit_string = (held_tag_ff == BIT_STRING_TAG);
      acc_shift     = (acc_ff << BYTE_W) | LENGTH_BITS'(b);
      acc_minus1    = acc_ff - LENGTH_BITS'(1);
   end

   // datapath registers next value
   always_comb begin
      held_tag_in   = held_tag_ff;
      held_avail_in = held_avail_ff;
      acc_in        = acc_ff;
      ext_left_in   = ext_left_ff;
      ext_total_in  = ext_total_ff;
      if (item.start_of_element) begin
         held_tag_in   = b;
         held_avail_in = item.bytes_available;
         acc_in        = '0;
         ext_left_in   = '0;
         ext_total_in  = '0;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               if (b[BYTE_W-1]) begin
                  if (ext_ok) begin
                     ext_total_in = n;
                     ext_left_in  = n;
                     acc_in       = '0;
                  end
               end else begin
                  acc_in = LENGTH_BITS'(b);
               end
            end
            PH_EXT: begin
               acc_in      = acc_shift;
               ext_left_in = ext_left_ff - COUNT_W'(1);
            end
            default: ;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item.start_of_element) begin
         phase_in = ({1'b0, item.bytes_available} < SHORT_HEADER) ? PH_IDLE : PH_LEN;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               if (b[BYTE_W-1]) begin
                  if (!ext_ok) begin
                     phase_in = PH_IDLE;
                  end else if (n != '0) begin
                     phase_in = PH_EXT;
                  end else begin
                     // zero count gives length zero, an empty bit string faults
                     phase_in = PH_IDLE;
                  end
               end else begin
                  phase_in = (is_bit_string && b != '0) ? PH_PAD : PH_IDLE;
               end
            end
            PH_EXT: begin
               if (ext_left_ff == COUNT_W'(1)) begin
                  phase_in = (is_bit_string && acc_shift != '0) ? PH_PAD : PH_IDLE;
               end
            end
            PH_PAD:  phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // result of this step
   always_comb begin
      logic [63:0] len_wide;
      len_wide              = 64'(acc_ff);
      emit                  = 1'b0;
      result.status         = 1'b1;
      result.tag_value      = held_tag_ff;
      result.content_length = '0;
      result.content_offset = '0;
      if (item.start_of_element) begin
         result.tag_value = b;
         emit = ({1'b0, item.bytes_available} < SHORT_HEADER);
      end else begin
         case (phase_ff)
            PH_LEN: begin
               if (b[BYTE_W-1]) begin
                  if (!ext_ok) begin
                     emit = 1'b1;
                  end else if (n == '0) begin
                     emit = 1'b1;
                     if (!is_bit_string) begin
                        result.status         = 1'b0;
                        result.content_offset = SHORT_OFFSET;
                     end
                  end
               end else if (!is_bit_string || b == '0) begin
                  emit = 1'b1;
                  if (!is_bit_string) begin
                     result.status         = 1'b0;
                     result.content_length = LEN_W'(b);
                     result.content_offset = SHORT_OFFSET;
                  end
               end
            end
            PH_EXT: begin
               if (ext_left_ff == COUNT_W'(1)) begin
                  len_wide = 64'(acc_shift);
                  if (!is_bit_string) begin
                     emit                  = 1'b1;
                     result.status         = 1'b0;
                     result.content_length = len_wide[LEN_W-1:0];
                     result.content_offset = SHORT_OFFSET + OFFSET_W'(ext_total_ff);
                  end else if (acc_shift == '0) begin
                     emit = 1'b1;
                  end
               end
            end
            PH_PAD: begin
               emit = 1'b1;
               if (b == '0) begin
                  len_wide              = 64'(acc_minus1);
                  result.status         = 1'b0;
                  result.content_length = len_wide[LEN_W-1:0];
                  result.content_offset = SHORT_OFFSET + OFFSET_W'(ext_total_ff)
                                          + OFFSET_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // result register valid next value
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   // parse context
   always_ff @(posedge clock) begin
      if (reset) begin
         held_tag_ff   <= '0;
         held_avail_ff <= '0;
         acc_ff        <= '0;
         ext_left_ff   <= '0;
         ext_total_ff  <= '0;
      end else if (advance) begin
         held_tag_ff   <= held_tag_in;
         held_avail_ff <= held_avail_in;
         acc_ff        <= acc_in;
         ext_left_ff   <= ext_left_in;
         ext_total_ff  <= ext_total_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_result_ff <= result;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule

FILE: design/asn1_tlv_header_parser_top.sv
// asn1_tlv_header_parser_top: streaming parser for asn.1 element headers
// depends on athp_pkg, athp_in_stage and athp_parser
`timescale 1ns / 1ps

// Usage:
// Header bytes enter one per request on the req_ stream. A request with
// req_tuser high is the tag byte and also carries the bytes available
// from the tag onward; it restarts parsing and drops any header under way.
// The block answers on the rsp_ stream with one result per header: tag,
// content length, content offset and status in rsp_tuser (0 ok, 1 fault).
// Requests that complete nothing give no result; bytes outside a header
// are ignored.
// The request that completes a header passes the input register, then the
// result register, before its result appears.
// Throughput: one request per cycle while results are taken, set by the
// combinational step logic between the input and result registers.
// Reset clears the parse phase and both stream registers; the block is
// ready for requests once reset is released.
// When the receiver stalls, the waiting result holds and the input
// register fills; req_tready then drops until the result is taken.

module asn1_tlv_header_parser_top
   import athp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_byte[7:0], bytes_available[39:8]
   input  logic        req_tuser,  // start_of_element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // tag_value[7:0], content_length[39:8],
                                   // content_offset[44:40], zero fill
   output logic        rsp_tuser   // status
);

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type result;

   // unpack the request
   assign in_item.data_byte        = req_tdata[7:0];
   assign in_item.bytes_available  = req_tdata[39:8];
   assign in_item.start_of_element = req_tuser;

   // input register
   athp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // parse step and result register
   athp_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack the result
   assign rsp_tdata = {3'b000, result.content_offset, result.content_length,
                       result.tag_value};
   assign rsp_tuser = result.status;

endmodule

FILE: tb/sv/asn1_tlv_header_parser_top_tb.sv
// asn1_tlv_header_parser_top_tb: self-checking bench for the asn.1 tlv header parser
// drives header bytes on the req_ stream and checks every result against its own predictor
// depends on athp_pkg and asn1_tlv_header_parser_top
`timescale 1ns / 1ps

module asn1_tlv_header_parser_top_tb;
   import athp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;  // data_byte[7:0], bytes_available[39:8]
   logic        req_tuser;  // start_of_element
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;  // tag_value[7:0], content_length[39:8], content_offset[44:40]
   logic        rsp_tuser;  // status

   asn1_tlv_header_parser_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // predicted parser state
   phase_type          hdr_phase;
   logic [BYTE_W-1:0]  hdr_tag;
   logic [LEN_W-1:0]   hdr_length;
   logic [COUNT_W-1:0] hdr_left;
   logic [COUNT_W-1:0] hdr_count;
   logic [AVAIL_W-1:0] hdr_avail;

   // headers whose result has not arrived yet
   result_type pending_headers[$];

   int  mismatches;
   int  items_sent;
   bit  tx_steady;
   bit  rx_steady;
   int  hold_off_request;
   int  hold_left;
   int  rx_gap;
   int  rx_pick;
   result_type want;

   // clock, 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result of a finished header; a fault clears length and offset
   function automatic result_type close_header(input bit fault, input logic [LEN_W-1:0] len,
                                               input logic [OFFSET_W-1:0] off);
      result_type hdr;
      hdr.status         = fault;
      hdr.tag_value      = hdr_tag;
      hdr.content_length = fault ? '0 : len;
      hdr.content_offset = fault ? '0 : off;
      hdr_phase = PH_IDLE;
      return hdr;
   endfunction

   // length known: finish, or wait for the bit-string pad byte
   function automatic bit length_complete(output result_type hdr);
      hdr = '0;
      if (hdr_tag == BIT_STRING_TAG) begin
         if (hdr_length == '0) begin
            hdr = close_header(1'b1, '0, '0);
            return 1'b1;
         end
         hdr_phase = PH_PAD;
         return 1'b0;
      end
      hdr = close_header(1'b0, hdr_length, SHORT_OFFSET + OFFSET_W'(hdr_count));
      return 1'b1;
   endfunction

   // one header byte through the predictor; returns 1 when a result is due
   function automatic bit parse_step(input logic [7:0] b, input logic s,
                                     input logic [31:0] avail, output result_type hdr);
      logic [COUNT_W-1:0] n;
      hdr = '0;
      if (s) begin
         hdr_tag    = b;
         hdr_avail  = avail;
         hdr_length = '0;
         hdr_left   = '0;
         hdr_count  = '0;
         if ({1'b0, avail} < SHORT_HEADER) begin
            hdr = close_header(1'b1, '0, '0);
            return 1'b1;
         end
         hdr_phase = PH_LEN;
         return 1'b0;
      end
      case (hdr_phase)
         PH_LEN: begin
            if (b[7]) begin
               n = b[COUNT_W-1:0];
               if ({1'b0, hdr_avail} < SHORT_HEADER + (AVAIL_W+1)'(n)) begin
                  hdr = close_header(1'b1, '0, '0);
                  return 1'b1;
               end
               hdr_count  = n;
               hdr_left   = n;
               hdr_length = '0;
               if (n == '0) return length_complete(hdr);
               hdr_phase = PH_EXT;
               return 1'b0;
            end
            hdr_length = LEN_W'(b);
            return length_complete(hdr);
         end
         PH_EXT: begin
            // older bytes fall off the top of the accumulator
            hdr_length = {hdr_length[LEN_W-9:0], b};
            hdr_left   = hdr_left - 1'b1;
            if (hdr_left == '0) return length_complete(hdr);
            return 1'b0;
         end
         PH_PAD: begin
            if (b != 8'h00) begin
               hdr = close_header(1'b1, '0, '0);
               return 1'b1;
            end
            hdr = close_header(1'b0, hdr_length - 1'b1,
                               SHORT_OFFSET + OFFSET_W'(hdr_count) + 5'd1);
            return 1'b1;
         end
         default: begin
            hdr_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   // send one request; valid stays high when the next one follows at once
   task automatic send_item(input logic [7:0] b, input logic s, input logic [31:0] avail);
      int gap;
      result_type hdr;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {avail, b};
      req_tuser  <= s;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      // every accepted request counts, stray bytes included
      items_sent++;
      if (parse_step(b, s, avail, hdr)) pending_headers.push_back(hdr);
   endtask

   // one header with random content, now and then broken or followed by a stray byte
   task automatic send_random_header();
      logic [7:0]  tag;
      logic [7:0]  len_byte;
      logic [7:0]  ext_byte;
      logic [31:0] avail;
      int          n;
      int          k;
      int          r;
      int          cut;
      r   = $urandom_range(0, 99);
      tag = (r < 30) ? BIT_STRING_TAG : 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 5) avail = $urandom_range(0, 1);
      else if (r < 20) avail = $urandom;
      else avail = $urandom_range(2, 24);
      r = $urandom_range(0, 99);
      if (r < 5) begin
         n = 0;
         len_byte = 8'h00;
      end else if (r < 40) begin
         n = 0;
         len_byte = 8'($urandom_range(0, 127));
      end else begin
         n = (r < 90) ? $urandom_range(0, 4) : $urandom_range(5, 15);
         len_byte = {1'b1, 3'($urandom), 4'(n)};
         // buffer just long enough, or one byte short
         if ($urandom_range(0, 3) == 0) avail = n + 1 + $urandom_range(0, 1);
      end
      // a new start in the middle drops the header under way
      cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, n + 2) : 99;
      send_item(tag, 1'b1, avail);
      if (cut == 1) return;
      send_item(len_byte, 1'b0, $urandom);
      for (k = 0; k < n; k++) begin
         if (cut == k + 2) return;
         r = $urandom_range(0, 9);
         ext_byte = (r < 2) ? 8'h00 : (r < 3) ? 8'hff : 8'($urandom);
         send_item(ext_byte, 1'b0, $urandom);
      end
      if (tag == BIT_STRING_TAG)
         send_item(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00, 1'b0, $urandom);
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, $urandom);
   endtask

   // stop offering requests and wait for every expected result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_headers.size() != 0) @(posedge clock);
   endtask

   // extremes and each special case of the header format
   task automatic test_directed();
      send_item(8'hff, 1'b0, 32'hffffffff);  // stray byte while idle
      send_item(8'h30, 1'b1, 32'hffffffff);  // short form length
      send_item(8'h7f, 1'b0, 32'h0);
      send_item(8'hff, 1'b1, 32'd1);         // buffer too short for any header
      send_item(8'h00, 1'b1, 32'd0);
      send_item(8'h02, 1'b1, 32'd2);         // zero extended count
      send_item(8'h80, 1'b0, 32'h0);
      send_item(8'h04, 1'b1, 32'd3);         // extended count beyond the buffer
      send_item(8'h82, 1'b0, 32'h0);
      send_item(BIT_STRING_TAG, 1'b1, 32'd40);  // empty bit string
      send_item(8'h00, 1'b0, 32'h0);
      send_item(BIT_STRING_TAG, 1'b1, 32'd5);   // bit string with good pad
      send_item(8'h81, 1'b0, 32'h0);
      send_item(8'h05, 1'b0, 32'h0);
      send_item(8'h00, 1'b0, 32'h0);
      send_item(BIT_STRING_TAG, 1'b1, 32'd3);   // nonzero pad byte
      send_item(8'h01, 1'b0, 32'h0);
      send_item(8'h80, 1'b0, 32'h0);
      send_item(8'h10, 1'b1, 32'd9);         // restart in the middle of a header
      send_item(8'h83, 1'b0, 32'h0);
      send_item(8'h12, 1'b0, 32'h0);
      send_item(8'h05, 1'b1, 32'd2);
      send_item(8'h00, 1'b0, 32'h0);
   endtask

   // random headers, with stretches of no idling on either side
   task automatic test_random_headers(input int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
         if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
         send_random_header();
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // receiver holds off while short headers stream in back to back
   task automatic test_stalled_receiver();
      int k;
      hold_off_request = 120;
      tx_steady = 1'b1;
      for (k = 0; k < 30; k++) begin
         send_item(8'($urandom_range(4, 255)), 1'b1, $urandom_range(2, 255));
         send_item(8'($urandom_range(0, 127)), 1'b0, $urandom);
      end
      tx_steady = 1'b0;
   endtask

   // sender pauses until every result is in, then carries on
   task automatic test_drained_pause();
      int k;
      for (k = 0; k < 20; k++) send_random_header();
      wait_drained();
      for (k = 0; k < 20; k++) send_random_header();
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0h, got %0h", what, exp_val, got_val);
   endtask

   // receiver: random stalls, steady stretches and one long hold-off
   always @(posedge clock) begin
      if (hold_off_request > 0) begin
         hold_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else if (rx_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rx_pick = pick_gap();
         if (rx_pick == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rx_gap = rx_pick - 1;
         end
      end
   end

   // compare each accepted result with the oldest pending header
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_headers.size() == 0) begin
            note_mismatch("result with none expected", 32'h0, 32'(rsp_tdata[7:0]));
         end else begin
            want = pending_headers.pop_front();
            if (rsp_tuser !== want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_tuser));
            if (rsp_tdata[7:0] !== want.tag_value)
               note_mismatch("tag_value", 32'(want.tag_value), 32'(rsp_tdata[7:0]));
            if (rsp_tdata[39:8] !== want.content_length)
               note_mismatch("content_length", want.content_length, rsp_tdata[39:8]);
            if (rsp_tdata[44:40] !== want.content_offset)
               note_mismatch("content_offset", 32'(want.content_offset),
                             32'(rsp_tdata[44:40]));
         end
      end
   end

   // run limit
   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

   // test sequence
   initial begin
      mismatches       = 0;
      items_sent       = 0;
      tx_steady        = 1'b0;
      rx_steady        = 1'b0;
      hold_off_request = 0;
      hold_left        = 0;
      rx_gap           = 0;
      hdr_phase        = PH_IDLE;
      hdr_tag          = '0;
      hdr_length       = '0;
      hdr_left         = '0;
      hdr_count        = '0;
      hdr_avail        = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_headers(1450);
      test_stalled_receiver();
      test_drained_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_headers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
